// ===== rtl/core/dttl_pkg.sv =====
package dttl_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  localparam logic [2:0] OUT_STORED = 3'd0;
  localparam logic [2:0] OUT_DUP = 3'd1;
  localparam logic [2:0] OUT_FULL = 3'd2;
  localparam logic [2:0] OUT_FWD = 3'd3;
  localparam logic [2:0] OUT_DONE = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SWEEP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] seq_number;
    logic [7:0]  pkt_kind;
    logic [15:0] life_seconds;
    logic [15:0] packet_tag;
    logic [31:0] now_seconds;
    logic [31:0] next_hop;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] out_src;
    logic [31:0] out_dst;
    logic [31:0] out_seq;
    logic [7:0]  out_kind;
    logic [15:0] out_life;
    logic [15:0] out_tag;
    logic [31:0] forward_to;
    logic [4:0]  removed_count;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic            load;      // capture input item, clear read, write and removed counters
    logic            visit;     // examine entry at read index
    logic            store;     // append captured item
    logic            emit;      // load result register
    logic [2:0]      emit_code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sweep;
    logic scan_done;  // read index reached occupancy
    logic dup_hit;    // entry at read index matches keys
    logic live;       // entry at read index survives sweep
    logic full;
    logic out_busy;   // result register still held
  } dp_status_t;

endpackage

// ===== rtl/core/dttl_stream_if.sv =====
interface dttl_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/dttl_datapath.sv =====
module dttl_datapath import dttl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  dp_cmd_t    cmd_i,
  input  logic       out_take_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  logic [31:0] src_q [Depth];
  logic [31:0] dst_q [Depth];
  logic [31:0] seq_q [Depth];
  logic [7:0]  kind_q [Depth];
  logic [15:0] life_q [Depth];
  logic [31:0] stamp_q [Depth];
  logic [15:0] tag_q [Depth];

  in_item_t        item_q;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] rd_q, wr_q, rm_q;
  logic            out_valid_q;
  out_item_t       out_q, out_d;

  logic [IdxW-1:0] ri, wi;
  logic [31:0]     age;
  logic [15:0]     new_life;

  assign ri = rd_q[IdxW-1:0];
  assign wi = wr_q[IdxW-1:0];
  assign age = item_q.now_seconds - stamp_q[ri];
  assign new_life = life_q[ri] - age[15:0];

  // status toward controller
  assign status_o.is_sweep = item_q.command == CMD_SWEEP;
  assign status_o.scan_done = rd_q >= occ_q;
  assign status_o.dup_hit = src_q[ri] == item_q.src_addr && dst_q[ri] == item_q.dst_addr
                         && seq_q[ri] == item_q.seq_number && kind_q[ri] == item_q.pkt_kind;
  assign status_o.live = age < {16'd0, life_q[ri]};
  assign status_o.full = occ_q >= CntW'(Depth);
  assign status_o.out_busy = out_valid_q && !out_take_i;

  // compaction writes live entry at write index, which never passes read index
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      src_q[occ_q[IdxW-1:0]] <= item_q.src_addr;
      dst_q[occ_q[IdxW-1:0]] <= item_q.dst_addr;
      seq_q[occ_q[IdxW-1:0]] <= item_q.seq_number;
      kind_q[occ_q[IdxW-1:0]] <= item_q.pkt_kind;
      life_q[occ_q[IdxW-1:0]] <= item_q.life_seconds;
      stamp_q[occ_q[IdxW-1:0]] <= item_q.now_seconds;
      tag_q[occ_q[IdxW-1:0]] <= item_q.packet_tag;
    end else if (cmd_i.visit && status_o.is_sweep && status_o.live) begin
      src_q[wi] <= src_q[ri];
      dst_q[wi] <= dst_q[ri];
      seq_q[wi] <= seq_q[ri];
      kind_q[wi] <= kind_q[ri];
      life_q[wi] <= new_life;
      stamp_q[wi] <= item_q.now_seconds;
      tag_q[wi] <= tag_q[ri];
    end
    if (cmd_i.load) item_q <= item_i;
  end

  // occupancy update
  always_comb begin
    occ_d = occ_q;
    if (cmd_i.store) occ_d = occ_q + 1'b1;
    else if (cmd_i.emit && cmd_i.emit_code == OUT_DONE) occ_d = wr_q;
  end

  // counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      rd_q <= '0;
      wr_q <= '0;
      rm_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.load) begin
        rd_q <= '0;
        wr_q <= '0;
        rm_q <= '0;
      end else if (cmd_i.visit) begin
        rd_q <= rd_q + 1'b1;
        if (status_o.is_sweep) begin
          if (status_o.live) wr_q <= wr_q + 1'b1;
          else rm_q <= rm_q + 1'b1;
        end
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_take_i) out_valid_q <= 1'b0;
    end
  end

  // next result contents
  always_comb begin
    out_d = '0;
    out_d.outcome = cmd_i.emit_code;
    out_d.last = cmd_i.emit_code != OUT_FWD;
    if (cmd_i.emit_code == OUT_DONE) out_d.removed_count = 5'(rm_q);
    if (cmd_i.emit_code == OUT_FWD) begin
      out_d.out_src = src_q[ri];
      out_d.out_dst = dst_q[ri];
      out_d.out_seq = seq_q[ri];
      out_d.out_kind = kind_q[ri];
      out_d.out_life = new_life;
      out_d.out_tag = tag_q[ri];
      out_d.forward_to = item_q.next_hop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== rtl/core/dttl_ctrl.sv =====
module dttl_ctrl import dttl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_e;
  state_e state_q;

  assign in_ready_o = state_q == S_IDLE;

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_SCAN: begin
        if (!status_i.out_busy) begin
          if (status_i.scan_done) begin
            cmd_o.emit = 1'b1;
            if (status_i.is_sweep) cmd_o.emit_code = OUT_DONE;
            else if (status_i.full) cmd_o.emit_code = OUT_FULL;
            else begin
              cmd_o.emit_code = OUT_STORED;
              cmd_o.store = 1'b1;
            end
          end else if (!status_i.is_sweep && status_i.dup_hit) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_code = OUT_DUP;
          end else begin
            cmd_o.visit = 1'b1;
            if (status_i.is_sweep && status_i.live) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_code = OUT_FWD;
            end
          end
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_SCAN;
        S_SCAN: if (cmd_o.emit && cmd_o.emit_code != OUT_FWD) state_q <= S_FINISH;
        S_FINISH: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dedup_ttl_forward_table_top.sv =====
// a transaction is accepted only in idle; the scan runs, the final result is registered,
// and the block returns to idle through a finish state before it takes the next one;
// the scan visits one stored entry per cycle and stalls while a result waits
// reset: asynchronous active low; table empties, stored entries undefined
module dedup_ttl_forward_table_top import dttl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  dttl_stream_if.sink   in_if,
  dttl_stream_if.source out_if
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dttl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .status_i(status), .cmd_o(cmd)
  );

  dttl_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i(in_if.data), .cmd_i(cmd),
    .out_take_i(out_if.ready), .status_o(status),
    .out_valid_o(out_if.valid), .out_data_o(out_if.data)
  );

endmodule

// ===== rtl/core/dttl_checker.sv =====
module dttl_checker import dttl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.last |-> !in_ready) else $error("accept mid sweep");

  // one transaction at a time: ready drops right after an accept
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");

  a_fwd_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.outcome == OUT_FWD |-> !out_data.last) else $error("bad last");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.outcome == OUT_DONE |-> out_data.forward_to == 32'd0)
    else $error("done carries entry");

endmodule

bind dedup_ttl_forward_table_top dttl_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
